// ----- src/vat_pkg.sv -----
// shared types and constants for the vertex affine transform
package vat_pkg;

   localparam int CoordW = 32;
   localparam int TrigW = 18;
   localparam int ModeW = 3;
   localparam int CsrIndexW = 3;
   localparam int ProdW = 2 * CoordW;
   localparam int FracW = 16;
   localparam int ShiftW = ProdW + 1 - FracW;

   localparam logic [ModeW-1:0] MODE_MOVE_X = 3'd0;
   localparam logic [ModeW-1:0] MODE_MOVE_Y = 3'd1;
   localparam logic [ModeW-1:0] MODE_MOVE_Z = 3'd2;
   localparam logic [ModeW-1:0] MODE_ROT_X = 3'd3;
   localparam logic [ModeW-1:0] MODE_ROT_Y = 3'd4;
   localparam logic [ModeW-1:0] MODE_ROT_Z = 3'd5;
   localparam logic [ModeW-1:0] MODE_SCALE = 3'd6;

   localparam logic [CsrIndexW-1:0] CSR_MODE = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_OFFSET = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_COS = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_SIN = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_SCALE = 3'd4;

   localparam logic signed [CoordW-1:0] Q_ONE = 32'sd65536;
   localparam logic signed [CoordW-1:0] COORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [CoordW-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic [TrigW-1:0] COS_RESET = 18'd65536;

   typedef struct packed {
      logic signed [CoordW-1:0] a_coef;
      logic signed [CoordW-1:0] a_val;
      logic signed [CoordW-1:0] b_coef;
      logic signed [CoordW-1:0] b_val;
   } opnd_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } adv_type;

endpackage

// ----- src/vertex_affine_transform.sv -----
// top level of the vertex affine transform pipeline
//
// usage: one vertex (x, y, z in signed Q16.16 plus a last flag) per transfer on
// the req_ channel, one transformed vertex per transfer on the rsp_ channel, in
// the same order. the csr_ channel writes mode, offset, cos, sin and scale
// registers; csr_ready is always high and writes to unknown indexes are dropped.
// registers should only change while no vertex is in flight.
// a req_ transfer passes through operand select, multiply, add and floor shift,
// and saturate before rsp_valid. throughput is one vertex per cycle while
// rsp_stall is low, set by the four register stages, each with its own valid bit.
// a stall on rsp_stall holds the output register; bubbles inside the pipe are
// squeezed out, so req_stall rises only once every stage is occupied.
// reset (synchronous, active high) empties the pipe and loads the register
// defaults: move x by zero, cos one, sin zero, scale one.
module vertex_affine_transform import vat_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [CoordW-1:0] req_x_in,
   input  logic signed [CoordW-1:0] req_y_in,
   input  logic signed [CoordW-1:0] req_z_in,
   input  logic                     req_last_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [CoordW-1:0] rsp_x_out,
   output logic signed [CoordW-1:0] rsp_y_out,
   output logic signed [CoordW-1:0] rsp_z_out,
   output logic                     rsp_saturated,
   output logic                     rsp_last_out,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexW-1:0]     csr_index,
   input  logic [CoordW-1:0]        csr_data
);

   logic [ModeW-1:0] mode_ff;
   logic signed [CoordW-1:0] offset_ff;
   logic signed [TrigW-1:0] cos_ff;
   logic signed [TrigW-1:0] sin_ff;
   logic signed [CoordW-1:0] scale_ff;
   logic csr_write;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic last1_ff, last2_ff, last3_ff, last4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   adv_type adv;

   opnd_type opx_in, opy_in, opz_in;
   opnd_type opx_ff, opy_ff, opz_ff;
   logic signed [CoordW-1:0] cos_w, sin_w, nsin_w;
   logic sat_x, sat_y, sat_z;

   // register file
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MOVE_X;
         offset_ff <= '0;
         cos_ff <= COS_RESET;
         sin_ff <= '0;
         scale_ff <= Q_ONE;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE: mode_ff <= csr_data[ModeW-1:0];
            CSR_OFFSET: offset_ff <= csr_data;
            CSR_COS: cos_ff <= csr_data[TrigW-1:0];
            CSR_SIN: sin_ff <= csr_data[TrigW-1:0];
            CSR_SCALE: scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline flow control
   assign rdy4 = ~v4_ff | ~rsp_stall;
   assign rdy3 = ~v3_ff | rdy4;
   assign rdy2 = ~v2_ff | rdy3;
   assign rdy1 = ~v1_ff | rdy2;
   assign req_stall = ~rdy1;
   assign adv = '{s2: rdy2, s3: rdy3, s4: rdy4};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // operand select: every lane computes a_coef*a_val + b_coef*b_val, then >>> 16
   assign cos_w = CoordW'(cos_ff);
   assign sin_w = CoordW'(sin_ff);
   assign nsin_w = -sin_w;

   always_comb begin
      opx_in = '{a_coef: Q_ONE, a_val: req_x_in, b_coef: '0, b_val: '0};
      opy_in = '{a_coef: Q_ONE, a_val: req_y_in, b_coef: '0, b_val: '0};
      opz_in = '{a_coef: Q_ONE, a_val: req_z_in, b_coef: '0, b_val: '0};
      case (mode_ff)
         MODE_MOVE_X: begin
            opx_in.b_coef = Q_ONE;
            opx_in.b_val = offset_ff;
         end
         MODE_MOVE_Y: begin
            opy_in.b_coef = Q_ONE;
            opy_in.b_val = offset_ff;
         end
         MODE_MOVE_Z: begin
            opz_in.b_coef = Q_ONE;
            opz_in.b_val = offset_ff;
         end
         MODE_ROT_X: begin
            opy_in = '{a_coef: cos_w, a_val: req_y_in, b_coef: nsin_w, b_val: req_z_in};
            opz_in = '{a_coef: sin_w, a_val: req_y_in, b_coef: cos_w, b_val: req_z_in};
         end
         MODE_ROT_Y: begin
            opx_in = '{a_coef: cos_w, a_val: req_x_in, b_coef: sin_w, b_val: req_z_in};
            opz_in = '{a_coef: cos_w, a_val: req_z_in, b_coef: nsin_w, b_val: req_x_in};
         end
         MODE_ROT_Z: begin
            opx_in = '{a_coef: cos_w, a_val: req_x_in, b_coef: nsin_w, b_val: req_y_in};
            opy_in = '{a_coef: sin_w, a_val: req_x_in, b_coef: cos_w, b_val: req_y_in};
         end
         MODE_SCALE: begin
            opx_in.a_coef = scale_ff;
            opy_in.a_coef = scale_ff;
            opz_in.a_coef = scale_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         opx_ff <= opx_in;
         opy_ff <= opy_in;
         opz_ff <= opz_in;
         last1_ff <= req_last_in;
      end
      if (rdy2) last2_ff <= last1_ff;
      if (rdy3) last3_ff <= last2_ff;
      if (rdy4) last4_ff <= last3_ff;
   end

   vat_lane u_lane_x (
      .clock     (clock),
      .adv       (adv),
      .opnd      (opx_ff),
      .coord_out (rsp_x_out),
      .sat_out   (sat_x)
   );

   vat_lane u_lane_y (
      .clock     (clock),
      .adv       (adv),
      .opnd      (opy_ff),
      .coord_out (rsp_y_out),
      .sat_out   (sat_y)
   );

   vat_lane u_lane_z (
      .clock     (clock),
      .adv       (adv),
      .opnd      (opz_ff),
      .coord_out (rsp_z_out),
      .sat_out   (sat_z)
   );

   assign rsp_valid = v4_ff;
   assign rsp_saturated = sat_x | sat_y | sat_z;
   assign rsp_last_out = last4_ff;

`ifndef NO_ASSERTIONS
   // input side stalls only when every stage holds an item
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // a clipped result sits at one of the range limits
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_x_out == COORD_MAX || rsp_x_out == COORD_MIN ||
          rsp_y_out == COORD_MAX || rsp_y_out == COORD_MIN ||
          rsp_z_out == COORD_MAX || rsp_z_out == COORD_MIN))
      else $error("saturation flag without a clipped coordinate");

   // an item in stage three reaches the output when nothing stalls
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rsp_stall) |=> rsp_valid)
      else $error("item lost between stage three and output");
`endif

endmodule

// ----- src/vat_lane.sv -----
// one coordinate lane: two products, floor shift and saturation
module vat_lane import vat_pkg::*; (
   input  logic                     clock,
   input  adv_type                  adv,
   input  opnd_type                 opnd,
   output logic signed [CoordW-1:0] coord_out,
   output logic                     sat_out
);

   logic signed [ProdW-1:0] prod_a_ff, prod_a_in;
   logic signed [ProdW-1:0] prod_b_ff, prod_b_in;
   logic signed [ProdW:0]   sum_w;
   logic signed [ShiftW-1:0] shift_ff, shift_in;
   logic signed [CoordW-1:0] coord_ff, coord_in;
   logic sat_ff, sat_in;
   logic in_range;

   assign prod_a_in = opnd.a_coef * opnd.a_val;
   assign prod_b_in = opnd.b_coef * opnd.b_val;

   assign sum_w = {prod_a_ff[ProdW-1], prod_a_ff} + {prod_b_ff[ProdW-1], prod_b_ff};
   // dropping the low bits floors toward negative infinity
   assign shift_in = sum_w[ProdW:FracW];

   assign in_range = (&shift_ff[ShiftW-1:CoordW-1]) | ~(|shift_ff[ShiftW-1:CoordW-1]);
   assign sat_in = ~in_range;
   always_comb begin
      if (in_range) begin
         coord_in = shift_ff[CoordW-1:0];
      end else if (shift_ff[ShiftW-1]) begin
         coord_in = COORD_MIN;
      end else begin
         coord_in = COORD_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
      if (adv.s3) begin
         shift_ff <= shift_in;
      end
      if (adv.s4) begin
         coord_ff <= coord_in;
         sat_ff <= sat_in;
      end
   end

   assign coord_out = coord_ff;
   assign sat_out = sat_ff;

endmodule
